// ===== hdl/swmv_pkg.sv =====
package swmv_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SQUARE_W    = 2 * SAMPLE_W;
    localparam int SUM_OUT_W   = 20;
    localparam int MEAN_W      = 16;
    localparam int SPREAD_W    = 36;
    localparam int SHIFT_W     = 6;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd23;

    // sample leaving the ring stage: new value and the entry it replaced
    typedef struct packed {
        logic [SAMPLE_W-1:0] fresh;
        logic [SAMPLE_W-1:0] old;
    } t_ring_word;

endpackage

// ===== hdl/swmv_ifc.sv =====
interface swmv_sample_if;
    logic                          valid;
    logic                          ready;
    logic [swmv_pkg::SAMPLE_W-1:0] sample_magnitude;

    modport source (output valid, output sample_magnitude, input ready);
    modport sink   (input valid, input sample_magnitude, output ready);
endinterface

interface swmv_result_if;
    logic                           valid;
    logic                           ready;
    logic [swmv_pkg::SAMPLE_W-1:0]  newest_sample;
    logic [swmv_pkg::SUM_OUT_W-1:0] window_sum;
    logic [swmv_pkg::MEAN_W-1:0]    window_mean;
    logic [swmv_pkg::SPREAD_W-1:0]  scaled_spread;

    modport source (output valid, output newest_sample, output window_sum,
                    output window_mean, output scaled_spread, input ready);
    modport sink   (input valid, input newest_sample, input window_sum,
                    input window_mean, input scaled_spread, output ready);
endinterface

interface swmv_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [swmv_pkg::SHIFT_W-1:0] variance_shift;

    modport source (output valid, output variance_shift, input ready);
    modport sink   (input valid, input variance_shift, output ready);
endinterface

// ===== hdl/sliding_window_mean_variance_unit.sv =====
// Moving-window mean and spread over a stream of unsigned 16-bit samples.
// Takes one word per cycle, sustained while results are taken, and returns
// one result word per sample after the ring RAM read stage and six
// arithmetic stages (squarings, totals update, reciprocal multiply for the
// mean, mean squared, spread, shift). The ring of the last WINDOW_DEPTH
// samples sits in a RAM with a registered read; the oldest entry is read and
// the new sample written at the same address in the acceptance cycle
// (read-first), so no forwarding is needed. A per-entry live flag, cleared
// by reset, makes never-written entries read as zero; there is no clearing
// pass after reset. The result path is a stalling pipeline that compresses
// bubbles, so input is taken while a finished result waits. variance_shift
// resets to 23; write it only when idle, the block does not enforce it.
module sliding_window_mean_variance_unit #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    swmv_sample_if.sink    i_sample,
    swmv_result_if.source  o_result,
    swmv_cfg_if.sink       i_cfg
);

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_DEPTH - 1);

    logic [swmv_pkg::SHIFT_W-1:0] r_shift;

    // write pointer and per-entry live flags
    logic [ADDR_W-1:0]       r_slot, n_slot;
    logic [WINDOW_DEPTH-1:0] r_live;

    // ring stage
    logic                           r_v1;
    logic                           r_live1;
    logic [swmv_pkg::SAMPLE_W-1:0]  r_fresh1;
    logic [swmv_pkg::SAMPLE_W-1:0]  w_rdata;
    logic                           w_rdy1;
    logic                           w_stat_rdy;
    logic                           w_acc;
    swmv_pkg::t_ring_word           w_word;

    assign w_rdy1         = !r_v1 || w_stat_rdy;
    assign i_sample.ready = w_rdy1;
    assign w_acc          = i_sample.valid && w_rdy1;
    assign i_cfg.ready    = 1'b1;

    assign n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= swmv_pkg::SHIFT_RESET;
            r_slot  <= '0;
            r_live  <= '0;
            r_v1    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_shift <= i_cfg.variance_shift;
            end
            if (w_rdy1) begin
                r_v1 <= i_sample.valid;
            end
            if (w_acc) begin
                r_slot         <= n_slot;
                r_live[r_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_fresh1 <= i_sample.sample_magnitude;
            r_live1  <= r_live[r_slot];
        end
    end

    // oldest sample leaves, newest takes its place in the same cycle
    swmv_ram #(
        .WIDTH (swmv_pkg::SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_acc),
        .i_waddr (r_slot),
        .i_wdata (i_sample.sample_magnitude),
        .i_re    (w_acc),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    // entry never written counts as zero
    assign w_word.fresh = r_fresh1;
    assign w_word.old   = r_live1 ? w_rdata : '0;

    swmv_stats #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .o_ready  (w_stat_rdy),
        .i_word   (w_word),
        .i_shift  (r_shift),
        .o_result (o_result)
    );

endmodule

// ===== hdl/swmv_ram.sv =====
// simple dual-port RAM, registered read, read-first on address collision
module swmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/swmv_stats.sv =====
// totals update, mean by reciprocal multiply, spread and shift
module swmv_stats #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  swmv_pkg::t_ring_word         i_word,
    input  logic [swmv_pkg::SHIFT_W-1:0] i_shift,
    swmv_result_if.source                o_result
);

    localparam int LOG_D  = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = swmv_pkg::SAMPLE_W + LOG_D;
    localparam int SQ_W   = swmv_pkg::SQUARE_W + LOG_D;
    localparam int MULT_W = SUM_W + 2;
    localparam int PROD_W = SUM_W + MULT_W;
    localparam int K      = SUM_W + LOG_D;
    localparam longint unsigned MULT_L =
        ((64'd1 << K) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam logic [MULT_W-1:0] MULT     = MULT_W'(MULT_L);
    localparam logic [SQ_W-1:0]   DEPTH_SQ = SQ_W'(WINDOW_DEPTH);
    localparam int SW  = swmv_pkg::SAMPLE_W;
    localparam int QW  = swmv_pkg::SQUARE_W;
    localparam int MW  = swmv_pkg::MEAN_W;
    localparam int SPW = swmv_pkg::SPREAD_W;
    localparam int SOW = swmv_pkg::SUM_OUT_W;

    // stage valids
    logic r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6, w_rdy7;

    // running totals
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SQ_W-1:0]  r_sq, n_sq;

    logic [SW-1:0]     r_new2, r_old2, r_new3, r_new4, r_new5, r_new6;
    logic [QW-1:0]     r_sqn2, r_sqo2, r_msq5;
    logic [SUM_W-1:0]  r_sum3, r_sum4, r_sum5, r_sum6;
    logic [SQ_W-1:0]   r_sq3, r_sq4, r_sq5, r_raw6;
    logic [PROD_W-1:0] r_prod4;
    logic [MW-1:0]     r_mean5, r_mean6, w_mean4;
    logic [SQ_W+SPW-1:0] w_shifted;
    logic [SUM_W+SOW-1:0] w_sum_ext;

    logic [SW-1:0]  r_o_new;
    logic [SOW-1:0] r_o_sum;
    logic [MW-1:0]  r_o_mean;
    logic [SPW-1:0] r_o_spread;

    assign w_rdy7  = !r_v7 || o_result.ready;
    assign w_rdy6  = !r_v6 || w_rdy7;
    assign w_rdy5  = !r_v5 || w_rdy6;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = w_rdy2;

    assign n_sum = r_sum - SUM_W'(r_old2) + SUM_W'(r_new2);
    assign n_sq  = r_sq - SQ_W'(r_sqo2) + SQ_W'(r_sqn2);

    assign w_mean4   = r_prod4[K +: MW];
    assign w_shifted = {{SPW{1'b0}}, r_raw6} >> i_shift;
    assign w_sum_ext = {{SOW{1'b0}}, r_sum6};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_sum <= '0;
            r_sq  <= '0;
        end else begin
            if (w_rdy2) r_v2 <= i_valid;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
            if (w_rdy6) r_v6 <= r_v5;
            if (w_rdy7) r_v7 <= r_v6;
            if (w_rdy3 && r_v2) begin
                r_sum <= n_sum;
                r_sq  <= n_sq;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_rdy2 && i_valid) begin
            r_new2 <= i_word.fresh;
            r_old2 <= i_word.old;
            r_sqn2 <= QW'(i_word.fresh) * QW'(i_word.fresh);
            r_sqo2 <= QW'(i_word.old) * QW'(i_word.old);
        end
        if (w_rdy3 && r_v2) begin
            r_new3 <= r_new2;
            r_sum3 <= n_sum;
            r_sq3  <= n_sq;
        end
        if (w_rdy4 && r_v3) begin
            r_new4  <= r_new3;
            r_sum4  <= r_sum3;
            r_sq4   <= r_sq3;
            r_prod4 <= PROD_W'(r_sum3) * PROD_W'(MULT);
        end
        if (w_rdy5 && r_v4) begin
            r_new5  <= r_new4;
            r_sum5  <= r_sum4;
            r_sq5   <= r_sq4;
            r_mean5 <= w_mean4;
            r_msq5  <= QW'(w_mean4) * QW'(w_mean4);
        end
        if (w_rdy6 && r_v5) begin
            r_new6  <= r_new5;
            r_sum6  <= r_sum5;
            r_mean6 <= r_mean5;
            r_raw6  <= r_sq5 - SQ_W'(r_msq5) * DEPTH_SQ;
        end
        if (w_rdy7 && r_v6) begin
            r_o_new    <= r_new6;
            r_o_sum    <= w_sum_ext[SOW-1:0];
            r_o_mean   <= r_mean6;
            r_o_spread <= w_shifted[SPW-1:0];
        end
    end

    assign o_result.valid         = r_v7;
    assign o_result.newest_sample = r_o_new;
    assign o_result.window_sum    = r_o_sum;
    assign o_result.window_mean   = r_o_mean;
    assign o_result.scaled_spread = r_o_spread;

endmodule

// ===== hdl/swmv_check.sv =====
module swmv_check #(
    parameter int WINDOW_DEPTH = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [swmv_pkg::SUM_OUT_W-1:0] i_out_sum,
    input logic [swmv_pkg::MEAN_W-1:0]    i_out_mean
);

    localparam logic [27:0] DEPTH_C = 28'(WINDOW_DEPTH);

    logic [3:0]  r_pend;
    logic [27:0] w_lo;
    logic [27:0] w_sum;

    assign w_lo  = 28'(i_out_mean) * DEPTH_C;
    assign w_sum = 28'(i_out_sum);

    // words accepted and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 4'(i_in_valid && i_in_ready)
                             - 4'(i_out_valid && i_out_ready);
        end
    end

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 4'd0)
        else $error("result word with no sample outstanding");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (WINDOW_DEPTH > 16) ||
                        (w_lo <= w_sum && w_sum < w_lo + DEPTH_C))
        else $error("mean does not match window sum");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

endmodule

bind sliding_window_mean_variance_unit swmv_check #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
) u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_sum   (o_result.window_sum),
    .i_out_mean  (o_result.window_mean)
);
